/* hw/rtl/sll_pkg.sv */
// shared field widths and stream packing for the linked-list insert block
package sll_pkg;

  localparam int POS_W       = 10;
  localparam int VAL_W       = 32;
  localparam int SLOT_W      = 10;

  // slave-side tdata: position, value, zero pad to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int IN_POS_LO   = 0;
  localparam int IN_VAL_LO   = IN_POS_LO + POS_W;

  // master-side tdata: ok, slot, zero pad to whole bytes
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_OK_BIT  = 0;
  localparam int OUT_SLOT_LO = 1;
  localparam int OUT_PAD_LO  = OUT_SLOT_LO + SLOT_W;

endpackage

/* hw/rtl/static_linked_list_insert.sv */
// top level of the cursor-linked list insert block
//
// Each transfer on the slave side asks to insert a value before a 1-based
// position of a list held in a slot store of SLOTS entries; one result
// (ok, slot) leaves on the master side for every request. Positions outside
// 1 to length+1, and requests while all SLOTS-2 element slots are used, give
// ok=0 and slot=0 and leave the list untouched. Free slots are handed out in
// ascending order (1, 2, ...), since nothing is ever removed. An accepted
// request first walks from the list head, which follows one link per cycle
// through the single read port of the link ram, to its insertion point;
// then the new slot's link is written, and after it the predecessor's
// link, but at the front of the list the head link register is updated
// together with the new slot's link. A rejected request skips these steps.
// The result waits in the done state while the master side stalls.
// A new request is taken once the previous result has been loaded into the
// output register, even while that result still waits there. No clearing
// pass follows reset: the free chain is a counter and the head link a
// register, so every ram entry is written before it is first read.
module static_linked_list_insert #(
  parameter int SLOTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] position, [41:10] value, [47:42] zero
  input  logic [sll_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] ok, [10:1] slot, [15:11] zero
  output logic [sll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // link width follows the slot count; compare width covers both position and length
  localparam int LW = $clog2(SLOTS);
  localparam int CW = ((LW > sll_pkg::POS_W) ? LW : sll_pkg::POS_W) + 1;
  localparam logic [LW-1:0] HEAD_SLOT = LW'(SLOTS - 1);
  localparam logic [LW-1:0] MAX_LEN   = LW'(SLOTS - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLICE,
    ST_FIX,
    ST_DONE
  } state_t;

  state_t                    state;
  logic [sll_pkg::POS_W-1:0] steps;      // links still to follow
  logic [LW-1:0]             cur;        // walk cursor when not taken from the ram
  logic                      pend;       // ram read data holds the new cursor
  logic [LW-1:0]             prev;       // node after which the new slot goes
  logic                      prev_head;  // that node is the list head
  logic [LW-1:0]             fresh;      // slot taken for this request
  logic                      ok;
  logic [LW-1:0]             head_link;  // link of the head slot, kept out of the ram
  logic [LW-1:0]             len;        // element count

  // input fields
  logic [sll_pkg::POS_W-1:0] in_pos;
  logic [sll_pkg::VAL_W-1:0] in_val;
  logic                      accept;
  logic                      bad;
  logic [CW-1:0]             pos_ext;
  logic [CW-1:0]             len_ext;
  logic [LW-1:0]             fresh_now;
  logic [CW-1:0]             fresh_ext;
  logic                      out_free;

  // link ram ports
  logic                      lnk_wr_en;
  logic [LW-1:0]             lnk_wr_addr;
  logic [LW-1:0]             lnk_wr_data;
  logic                      lnk_rd_en;
  logic [LW-1:0]             lnk_rd_data;
  logic [LW-1:0]             cur_eff;
  logic [LW-1:0]             next_link;

  assign in_pos = s_axis_tdata[sll_pkg::IN_POS_LO +: sll_pkg::POS_W];
  assign in_val = s_axis_tdata[sll_pkg::IN_VAL_LO +: sll_pkg::VAL_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // reject position zero, past the end, or a full store
  assign pos_ext   = CW'(in_pos);
  assign len_ext   = CW'(len);
  assign fresh_now = len + LW'(1);
  assign bad       = (in_pos == '0) || (pos_ext > (len_ext + CW'(1))) || (len == MAX_LEN);

  // cursor comes straight from the ram the cycle after a read
  assign cur_eff   = pend ? lnk_rd_data : cur;
  // successor of the insertion point
  assign next_link = prev_head ? head_link : lnk_rd_data;

  assign lnk_rd_en = (state == ST_WALK) && (cur_eff != HEAD_SLOT);

  always_comb begin
    lnk_wr_en   = 1'b0;
    lnk_wr_addr = fresh;
    lnk_wr_data = next_link;
    unique case (state)
      ST_SPLICE: begin
        lnk_wr_en = 1'b1;
      end
      ST_FIX: begin
        lnk_wr_en   = 1'b1;
        lnk_wr_addr = prev;
        lnk_wr_data = fresh;
      end
      default: begin
        lnk_wr_en = 1'b0;
      end
    endcase
  end

  sll_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (lnk_wr_en),
    .wr_addr (lnk_wr_addr),
    .wr_data (lnk_wr_data),
    .rd_en   (lnk_rd_en),
    .rd_addr (cur_eff),
    .rd_data (lnk_rd_data)
  );

  // element values are only stored, the block itself never reads them back
  sll_ram #(
    .WIDTH (sll_pkg::VAL_W),
    .DEPTH (SLOTS)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (accept && !bad),
    .wr_addr (fresh_now),
    .wr_data (in_val),
    .rd_en   (1'b0),
    .rd_addr (fresh_now),
    .rd_data ()
  );

  assign fresh_ext = CW'(fresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pend          <= 1'b0;
      len           <= '0;
      head_link     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result taken; the done state reloads the register in the same cycle
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur   <= HEAD_SLOT;
            pend  <= 1'b0;
            steps <= in_pos - sll_pkg::POS_W'(1);
            fresh <= fresh_now;
            if (bad) begin
              ok    <= 1'b0;
              state <= ST_DONE;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (steps == '0) begin
            // read of the successor was issued this cycle unless at the head
            prev      <= cur_eff;
            prev_head <= (cur_eff == HEAD_SLOT);
            pend      <= 1'b0;
            state     <= ST_SPLICE;
          end else begin
            steps <= steps - sll_pkg::POS_W'(1);
            if (cur_eff == HEAD_SLOT) begin
              cur  <= head_link;
              pend <= 1'b0;
            end else begin
              cur  <= cur_eff;
              pend <= 1'b1;
            end
          end
        end
        ST_SPLICE: begin
          // new slot takes over the successor link
          if (prev_head) begin
            head_link <= fresh;
            len       <= len + LW'(1);
            ok        <= 1'b1;
            state     <= ST_DONE;
          end else begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          len   <= len + LW'(1);
          ok    <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            // pad, slot (zero on a refusal), ok
            m_axis_tdata  <= {{(sll_pkg::OUT_TDATA_W - sll_pkg::OUT_PAD_LO){1'b0}},
                              {sll_pkg::SLOT_W{ok}} & fresh_ext[sll_pkg::SLOT_W-1:0],
                              ok};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/sll_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
module sll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/sll_checker.sv */
// port-level checks for the linked-list insert block, bound to the top level
module sll_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [sll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // nothing left over from before reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a failed insert reports slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[sll_pkg::OUT_OK_BIT]
      |-> m_axis_tdata[sll_pkg::OUT_SLOT_LO +: sll_pkg::SLOT_W] == '0)
    else $error("failed insert with nonzero slot");

  // a successful insert never reports slot zero
  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[sll_pkg::OUT_OK_BIT]
      |-> m_axis_tdata[sll_pkg::OUT_SLOT_LO +: sll_pkg::SLOT_W] != '0)
    else $error("successful insert reports slot zero");

  // a request taken in one cycle is never answered in the next
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

endmodule

bind static_linked_list_insert sll_checker u_sll_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
